// ===== rtl/i2rt_pkg.sv =====
// Shared types, constants and digit lookup for the radix text converter.
`timescale 1ns / 1ps
`default_nettype none
package i2rt_pkg;
    localparam int MAX_DIGITS_DEF = 64;
    localparam int VALUE_W        = 64;
    localparam int CNT_W          = 7;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] ERROR_CHAR = 8'h00;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic [4:0]         radix;
        logic               negative;
        logic               error;
    } t_job;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else begin
            c = 8'h37 + {4'd0, d};
        end
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/integer_to_radix_text_top.sv =====
// Top level of the integer to radix text converter.
`timescale 1ns / 1ps
`default_nettype none
// Converts a 64-bit value in a radix of 2 to 16 into ASCII characters, most
// significant first, with a leading '-' for negative signed values; invalid
// radix or the most negative signed value gives one error character. Each
// digit is found in the shared division unit (8 quotient bits per cycle),
// then the characters leave the output register one per cycle while the
// output is not stalled. A two-entry queue lets new transactions be
// accepted meanwhile.
module integer_to_radix_text_top import i2rt_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_signed_mode,
    input  wire logic [7:0]         i_radix,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_character,
    output logic                    o_last,
    output logic                    o_error
);
    t_job job_in, job_out;
    logic full, empty, pop;

    assign o_stall = full;

    i2rt_front u_front (
        .i_value(i_value), .i_signed_mode(i_signed_mode), .i_radix(i_radix),
        .o_job(job_in)
    );

    i2rt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_valid && !full),
        .i_job(job_in), .o_full(full), .o_empty(empty), .i_pop(pop),
        .o_job(job_out)
    );

    i2rt_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(job_out),
        .o_pop(pop), .o_valid(o_valid), .i_stall(i_stall),
        .o_character(o_character), .o_last(o_last), .o_error(o_error)
    );
endmodule
`default_nettype wire

// ===== rtl/i2rt_front.sv =====
// Front end: classifies an incoming transaction into a conversion job.
`timescale 1ns / 1ps
`default_nettype none
module i2rt_front import i2rt_pkg::*; (
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_signed_mode,
    input  wire logic [7:0]         i_radix,
    output t_job                    o_job
);
    logic radix_ok;
    logic neg;
    logic most_neg;

    always_comb begin
        radix_ok = (i_radix >= 8'd2) && (i_radix <= 8'd16);
        neg      = i_signed_mode & i_value[VALUE_W-1];
        most_neg = neg && (i_value[VALUE_W-2:0] == '0);
        o_job.radix    = i_radix[4:0];
        o_job.negative = neg;
        o_job.error    = !radix_ok || most_neg;
        o_job.mag      = neg ? (~i_value + VALUE_W'(1)) : i_value;
    end
endmodule
`default_nettype wire

// ===== rtl/i2rt_queue.sv =====
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module i2rt_queue import i2rt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_job      o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/i2rt_back.sv =====
// Back end: digit extraction by repeated division and character output.
`timescale 1ns / 1ps
`default_nettype none
module i2rt_back import i2rt_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic [7:0] o_character,
    output logic      o_last,
    output logic      o_error
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [VALUE_W-1:0]      r_quot, n_quot;
    logic [3:0]              r_rem, n_rem;
    logic [2:0]              r_step;
    logic [4:0]              r_radix;
    logic                    r_neg, r_err;
    logic [CNT_W-1:0]        r_cnt;
    logic [MAX_DIGITS*4-1:0] r_buf;
    logic                    r_ov, r_last, r_errout;
    logic [7:0]              r_char;
    logic                    out_free;
    logic [4:0]              t;
    logic [7:0]              total;

    assign out_free    = !r_ov || !i_stall;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_valid     = r_ov;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_error     = r_errout;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        for (int j = 0; j < 8; j++) begin
            t = {n_rem, n_quot[VALUE_W-1]};
            n_quot = {n_quot[VALUE_W-2:0], t >= r_radix};
            if (t >= r_radix) t = t - r_radix;
            n_rem = t[3:0];
        end
        total = 8'(r_cnt) + {7'd0, r_neg};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_empty) n_state = i_job.error ? S_OUT : S_DIV;
            S_DIV:   if (r_step == 3'd7 && n_quot == '0) n_state = S_OUT;
            S_OUT:   if (out_free && (r_err || (!r_neg && r_cnt == CNT_W'(1))))
                         n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_quot  <= i_job.mag;
                r_radix <= i_job.radix;
                r_neg   <= i_job.negative;
                r_err   <= i_job.error;
                r_rem   <= 4'd0;
                r_step  <= 3'd0;
                r_cnt   <= '0;
            end
            S_DIV: begin
                r_quot <= n_quot;
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_rem <= 4'd0;
                    r_buf <= {r_buf[MAX_DIGITS*4-5:0], n_rem};
                    r_cnt <= r_cnt + CNT_W'(1);
                end else begin
                    r_rem <= n_rem;
                end
                if (r_step == 3'd7 && n_quot == '0 &&
                    (8'(r_cnt) + 8'd1 + {7'd0, r_neg}) > 8'(MAX_DIGITS)) begin
                    r_err <= 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    if (r_err) begin
                        r_char   <= ERROR_CHAR;
                        r_last   <= 1'b1;
                        r_errout <= 1'b1;
                    end else if (r_neg) begin
                        r_char   <= MINUS_CHAR;
                        r_last   <= 1'b0;
                        r_errout <= 1'b0;
                        r_neg    <= 1'b0;
                    end else begin
                        r_char   <= digit_char(r_buf[3:0]);
                        r_last   <= (r_cnt == CNT_W'(1));
                        r_errout <= 1'b0;
                        r_buf    <= {4'd0, r_buf[MAX_DIGITS*4-1:4]};
                        r_cnt    <= r_cnt - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_errout |-> r_last) else $error("error item not last");
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_errout && r_char == MINUS_CHAR |-> !r_last)
        else $error("minus marked last");
    a_digits_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !r_err |-> r_cnt != '0 && total <= 8'(MAX_DIGITS))
        else $error("no digits to emit");
endmodule
`default_nettype wire

// ===== dv/integer_to_radix_text_top_test.sv =====
// Self-checking testbench for the integer to radix text converter.
`timescale 1ns / 1ps
module integer_to_radix_text_top_test;
    import i2rt_pkg::*;

    typedef struct {
        logic [63:0] value;
        logic        sgn;
        logic [7:0]  radix;
    } t_conv_req;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_text_char;

    localparam int MAX_CYCLES = 12000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_value = '0;
    logic        i_signed_mode = 1'b0;
    logic [7:0]  i_radix = 8'd10;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_character;
    logic        o_last;
    logic        o_error;

    t_conv_req  pending_reqs[$];
    t_text_char expected_text[$];
    int         mismatches = 0;
    int         cycles = 0;
    int         send_gap = 0;
    int         stall_len = 0;
    bit         stim_done = 1'b0;
    bit         hold_drain = 1'b0;

    integer_to_radix_text_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_value(i_value), .i_signed_mode(i_signed_mode), .i_radix(i_radix),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_character(o_character), .o_last(o_last), .o_error(o_error)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void predict_text(t_conv_req rq);
        logic [63:0] mag;
        logic [7:0]  digs[$];
        logic        neg;
        t_text_char  c;
        mag = rq.value;
        neg = 1'b0;
        if (rq.radix < 2 || rq.radix > 16) begin
            c = '{ERROR_CHAR, 1'b1, 1'b1};
            expected_text.push_back(c);
            return;
        end
        if (rq.sgn && mag[63]) begin
            if (mag == 64'h8000_0000_0000_0000) begin
                c = '{ERROR_CHAR, 1'b1, 1'b1};
                expected_text.push_back(c);
                return;
            end
            neg = 1'b1;
            mag = ~mag + 64'd1;
        end
        do begin
            logic [3:0] d;
            d = 4'(mag % 64'(rq.radix));
            digs.push_front(d < 10 ? 8'h30 + 8'(d) : 8'h37 + 8'(d));
            mag = mag / 64'(rq.radix);
        end while (mag != 0);
        if (neg) begin
            c = '{MINUS_CHAR, 1'b0, 1'b0};
            expected_text.push_back(c);
        end
        foreach (digs[i]) begin
            c = '{digs[i], i == digs.size() - 1, 1'b0};
            expected_text.push_back(c);
        end
    endfunction

    function automatic void add_req(logic [63:0] v, logic s, logic [7:0] r);
        t_conv_req rq;
        rq = '{v, s, r};
        pending_reqs.push_back(rq);
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        int          w;
        v = {$urandom, $urandom};
        w = $urandom_range(1, 64);
        case ($urandom_range(0, 3))
            0: v = v >> (64 - w);
            1: v = -(v >> (64 - w));
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic [7:0] r;
        add_req(64'd0, 1'b0, 8'd10);
        add_req(64'd0, 1'b1, 8'd2);
        add_req('1, 1'b0, 8'd2);
        add_req('1, 1'b1, 8'd2);
        add_req('1, 1'b0, 8'd16);
        add_req('1, 1'b0, 8'd10);
        add_req(64'h8000_0000_0000_0000, 1'b1, 8'd10);
        add_req(64'h8000_0000_0000_0000, 1'b0, 8'd10);
        add_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 8'd16);
        add_req(64'h8000_0000_0000_0001, 1'b1, 8'd10);
        add_req(64'hFEDC_BA98_7654_3210, 1'b0, 8'd16);
        add_req(64'd12345, 1'b0, 8'd0);
        add_req(64'd12345, 1'b0, 8'd1);
        add_req(64'd12345, 1'b1, 8'd17);
        add_req(64'd12345, 1'b0, 8'd255);
        add_req(64'd35, 1'b0, 8'd3);
        add_req(64'd255, 1'b0, 8'd15);
        add_req(64'd1, 1'b1, 8'd7);
        add_req(64'hFFFF_FFFF_FFFF_FF85, 1'b1, 8'd13);
        for (int i = 0; i < 480; i++) begin
            if ($urandom_range(0, 19) == 0) r = 8'($urandom);
            else r = 8'($urandom_range(2, 16));
            add_req(rand_value(), 1'($urandom), r);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 8) i_rst_n <= 1'b1;
        if (cycles > MAX_CYCLES) begin
            $display("integer_to_radix_text_top_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_text('{i_value, i_signed_mode, i_radix});
                pending_reqs.pop_front();
            end
            if (i_valid && o_stall) begin
            end else if (hold_drain) begin
                i_valid <= 1'b0;
                if (expected_text.size() == 0 && !(i_valid && !o_stall)) hold_drain <= 1'b0;
            end else if (pending_reqs.size() > 0 && send_gap == 0) begin
                i_valid       <= 1'b1;
                i_value       <= pending_reqs[0].value;
                i_signed_mode <= pending_reqs[0].sgn;
                i_radix       <= pending_reqs[0].radix;
                send_gap      <= rand_gap();
                if (pending_reqs.size() == 300) hold_drain <= 1'b1;
            end else begin
                i_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
                if (pending_reqs.size() == 0) stim_done <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_text.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected char %h", o_character);
                end else begin
                    t_text_char e;
                    e = expected_text.pop_front();
                    if (e.ch !== o_character || e.last !== o_last || e.err !== o_error) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b", e.ch, e.last,
                                     e.err, o_character, o_last, o_error);
                    end
                end
            end
            if (stall_len > 0) begin
                i_stall   <= 1'b1;
                stall_len <= stall_len - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall   <= 1'b1;
                stall_len <= rand_gap();
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        wait (stim_done && expected_text.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("integer_to_radix_text_top_test OK");
        end else begin
            $display("integer_to_radix_text_top_test NOT OK");
        end
        $finish;
    end
endmodule
